// ===== rtl/kalman_depth_velocity_estimator_core_defines.svh =====
// Assertion macros for the depth/velocity filter
`ifndef KALMAN_DEPTH_VELOCITY_ESTIMATOR_CORE_DEFINES_SVH
`define KALMAN_DEPTH_VELOCITY_ESTIMATOR_CORE_DEFINES_SVH

`define KDV_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define KDV_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/kdv_pkg.sv =====
package kdv_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DataW    = 32;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 21;
  localparam int unsigned DtW      = 17;
  localparam int unsigned NoiseW   = 21;
  localparam int unsigned IoW      = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIME_STEP = 2'd0,
    CFG_DEPTH_Q   = 2'd1,
    CFG_VEL_Q     = 2'd2,
    CFG_MEAS_R    = 2'd3
  } cfg_idx_e;

  localparam logic [DtW-1:0]    DtReset = 17'd1311;
  localparam logic [NoiseW-1:0] QdReset = 21'd1311;
  localparam logic [NoiseW-1:0] QvReset = 21'd3277;
  localparam logic [NoiseW-1:0] RReset  = 21'd16384;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ED,     // ed = sat(ed + dt*ev)
    ST_T,      // t = pvd + pdv
    ST_P00A,   // p00 = pdd + dt*t
    ST_DT2,    // a = dt*dt
    ST_P00B,   // p00 += a*pvv
    ST_P00Q,   // p00 += qd
    ST_P01,    // p01 = pdv + dt*pvv
    ST_P10,    // p10 = pvd + dt*pvv
    ST_P11,    // p11 = pvv + qv
    ST_Y,      // y = z - ed
    ST_S,      // s = p00 + r
    ST_K0,     // divide p00/s
    ST_K1,     // divide p10/s
    ST_EDU,
    ST_EVU,
    ST_OMK,
    ST_PDD,
    ST_PDV,
    ST_PVD,
    ST_PVV,
    ST_OUT
  } state_e;

endpackage

// ===== rtl/kalman_depth_velocity_estimator_core.sv =====
// Constant-velocity Kalman filter for one depth sensor, two states.
// Input channel: measured_depth_i with in_valid_i/in_ready_o; one transaction
// per depth sample, signed Q16.16.
// Output channel: depth_estimate_o/velocity_estimate_o with out_valid_o and
// out_ready_i; exactly one result transaction per sample.
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i, for time step, depth and velocity process
// noise, measurement noise; to be written only while idle, which the block does not enforce.
// Each sample walks a sequencer through the predict and update steps on one
// shared rounding multiplier and one shared add/saturate path; the two gain
// divisions run on a restoring divider, one quotient bit per cycle.
// Most of the time from the accepting edge to out_valid_o goes to the two
// serial divisions.
// A new sample is taken only once the sequencer is back to idle; the input
// is ready again there, so samples are not overlapped.
// Reset: estimates go to zero, covariance to identity, registers to defaults.
// A stalled receiver holds the result in the output register; the next sample
// is still taken, but its result waits at the hand-over step until the
// pending one is accepted, and the input stays not ready meanwhile.
module kalman_depth_velocity_estimator_core
  import kdv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [IoW-1:0] measured_depth_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [IoW-1:0] depth_estimate_o,
  output logic signed [IoW-1:0] velocity_estimate_o
);

  localparam int unsigned W   = DataW;
  localparam int unsigned PW  = 2 * W + 1;
  localparam int unsigned NDIV = W + FracBits;
  localparam int unsigned CW  = $clog2(NDIV + 1);
  localparam logic signed [W-1:0] SMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMin = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] OneQ = W'(1) << FracBits;

  typedef logic signed [W-1:0] dat_t;

  state_e state_q, state_d;

  logic [DtW-1:0]    dt_q;
  logic [NoiseW-1:0] qd_q, qv_q, r_q;

  dat_t ed_q, ev_q, pdd_q, pdv_q, pvd_q, pvv_q;
  dat_t z_q, t_q, a_q, p00_q, p01_q, p10_q, p11_q, y_q, s_q, k0_q, k1_q, omk_q;
  dat_t od_q, ov_q;
  logic out_valid_q;

  // divider
  logic [W-1:0]  dn_q;        // dividend magnitude
  logic [W:0]    dr_q;        // partial remainder
  logic [W+1:0]  dq_q;        // quotient, capped
  logic          dneg_q;
  logic [CW-1:0] dcnt_q;
  logic          dbusy_q;

  // shared multiplier operands
  dat_t ma, mb;
  dat_t mres;
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      ST_ED:   begin ma = dat_t'(dt_q); mb = ev_q;  end
      ST_P00A: begin ma = dat_t'(dt_q); mb = t_q;   end
      ST_DT2:  begin ma = dat_t'(dt_q); mb = dat_t'(dt_q); end
      ST_P00B: begin ma = a_q;          mb = pvv_q; end
      ST_P01:  begin ma = dat_t'(dt_q); mb = pvv_q; end
      ST_P10:  begin ma = dat_t'(dt_q); mb = pvv_q; end
      ST_EDU:  begin ma = k0_q;         mb = y_q;   end
      ST_EVU:  begin ma = k1_q;         mb = y_q;   end
      ST_PDD:  begin ma = omk_q;        mb = p00_q; end
      ST_PDV:  begin ma = omk_q;        mb = p01_q; end
      ST_PVD:  begin ma = k1_q;         mb = p00_q; end
      ST_PVV:  begin ma = k1_q;         mb = p01_q; end
      default: ;
    endcase
  end

  logic [W-1:0]  mag_a, mag_b;
  logic [2*W-1:0] prod;
  logic [2*W:0]  prnd;
  logic [2*W:0]  pm;
  logic          mneg;
  always_comb begin
    mag_a = ma[W-1] ? W'(-ma) : W'(ma);
    mag_b = mb[W-1] ? W'(-mb) : W'(mb);
    prod  = mag_a * mag_b;
    prnd  = {1'b0, prod} + ((2*W+1)'(1) << (FracBits - 1));
    pm    = prnd >> FracBits;
    mneg  = ma[W-1] ^ mb[W-1];
    if (mneg) begin
      if (pm > (PW)'({1'b1, {(W-1){1'b0}}})) mres = SMin;
      else mres = dat_t'(-pm[W-1:0]);
    end else begin
      if (pm > (PW)'(SMax)) mres = SMax;
      else mres = dat_t'(pm[W-1:0]);
    end
  end

  // shared adder
  dat_t aa, ab;
  logic asub;
  dat_t ares;
  logic signed [W:0] asum;
  always_comb begin
    aa = '0;
    ab = '0;
    asub = 1'b0;
    case (state_q)
      ST_ED:   begin aa = ed_q;  ab = mres; end
      ST_T:    begin aa = pvd_q; ab = pdv_q; end
      ST_P00A: begin aa = pdd_q; ab = mres; end
      ST_P00B: begin aa = p00_q; ab = mres; end
      ST_P00Q: begin aa = p00_q; ab = dat_t'(qd_q); end
      ST_P01:  begin aa = pdv_q; ab = mres; end
      ST_P10:  begin aa = pvd_q; ab = mres; end
      ST_P11:  begin aa = pvv_q; ab = dat_t'(qv_q); end
      ST_Y:    begin aa = z_q;   ab = ed_q; asub = 1'b1; end
      ST_S:    begin aa = p00_q; ab = dat_t'(r_q); end
      ST_EDU:  begin aa = ed_q;  ab = mres; end
      ST_EVU:  begin aa = ev_q;  ab = mres; end
      ST_OMK:  begin aa = OneQ;  ab = k0_q; asub = 1'b1; end
      ST_PVD:  begin aa = p10_q; ab = mres; asub = 1'b1; end
      ST_PVV:  begin aa = p11_q; ab = mres; asub = 1'b1; end
      default: ;
    endcase
    asum = asub ? ((W+1)'(aa) - (W+1)'(ab)) : ((W+1)'(aa) + (W+1)'(ab));
    if (asum[W] != asum[W-1]) ares = asum[W] ? SMin : SMax;
    else ares = asum[W-1:0];
  end

  // divider step
  logic [W:0]   rsh;
  logic         rge;
  logic [W+1:0] qn;
  logic         nbit;
  logic [W+1:0] cap;
  always_comb begin
    cap  = (W+2)'(1) << (W - 1);
    nbit = (dcnt_q > CW'(FracBits)) ? dn_q[W-1] : 1'b0;
    rsh  = {dr_q[W-1:0], nbit};
    rge  = rsh >= {1'b0, s_q};
    qn   = {dq_q[W:0], rge};
    if (qn > cap) qn = cap + (W+2)'(1);
  end

  logic in_acc, out_acc, dlast;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_q && out_ready_i;
  assign dlast   = dbusy_q && (dcnt_q == CW'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_ED;
      ST_ED:   state_d = ST_T;
      ST_T:    state_d = ST_P00A;
      ST_P00A: state_d = ST_DT2;
      ST_DT2:  state_d = ST_P00B;
      ST_P00B: state_d = ST_P00Q;
      ST_P00Q: state_d = ST_P01;
      ST_P01:  state_d = ST_P10;
      ST_P10:  state_d = ST_P11;
      ST_P11:  state_d = ST_Y;
      ST_Y:    state_d = ST_S;
      ST_S:    state_d = ST_K0;
      ST_K0:   if (s_q[W-1] || s_q == '0 || dlast) state_d = ST_K1;
      ST_K1:   if (s_q[W-1] || s_q == '0 || dlast) state_d = ST_EDU;
      ST_EDU:  state_d = ST_EVU;
      ST_EVU:  state_d = ST_OMK;
      ST_OMK:  state_d = ST_PDD;
      ST_PDD:  state_d = ST_PDV;
      ST_PDV:  state_d = ST_PVD;
      ST_PVD:  state_d = ST_PVV;
      ST_PVV:  state_d = ST_OUT;
      ST_OUT:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      dbusy_q     <= 1'b0;
      dcnt_q      <= '0;
      dt_q  <= DtReset;
      qd_q  <= QdReset;
      qv_q  <= QvReset;
      r_q   <= RReset;
      ed_q  <= '0;
      ev_q  <= '0;
      pdd_q <= OneQ;
      pdv_q <= '0;
      pvd_q <= '0;
      pvv_q <= OneQ;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TIME_STEP: dt_q <= cfg_data_i[DtW-1:0];
          CFG_DEPTH_Q:   qd_q <= cfg_data_i;
          CFG_VEL_Q:     qv_q <= cfg_data_i;
          CFG_MEAS_R:    r_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_acc) out_valid_q <= 1'b0;
      case (state_q)
        ST_ED:   ed_q <= ares;
        ST_EDU:  ed_q <= ares;
        ST_EVU:  ev_q <= ares;
        ST_PDD:  pdd_q <= mres;
        ST_PDV:  pdv_q <= mres;
        ST_PVD:  pvd_q <= ares;
        ST_PVV:  pvv_q <= ares;
        default: ;
      endcase
      if ((state_q == ST_K0 || state_q == ST_K1) && !(s_q[W-1] || s_q == '0)) begin
        if (!dbusy_q) begin
          dbusy_q <= 1'b1;
          dcnt_q  <= CW'(NDIV);
        end else begin
          dcnt_q <= dcnt_q - CW'(1);
          if (dlast) dbusy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) z_q <= dat_t'(measured_depth_i);
    case (state_q)
      ST_T:    t_q   <= ares;
      ST_P00A: p00_q <= ares;
      ST_DT2:  a_q   <= mres;
      ST_P00B: p00_q <= ares;
      ST_P00Q: p00_q <= ares;
      ST_P01:  p01_q <= ares;
      ST_P10:  p10_q <= ares;
      ST_P11:  p11_q <= ares;
      ST_Y:    y_q   <= ares;
      ST_S:    s_q   <= ares;
      ST_OMK:  omk_q <= ares;
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          od_q <= ed_q;
          ov_q <= ev_q;
        end
      end
      default: ;
    endcase
    if (state_q == ST_K0 || state_q == ST_K1) begin
      if (s_q[W-1] || s_q == '0) begin
        if (state_q == ST_K0) k0_q <= '0;
        else k1_q <= '0;
      end else if (!dbusy_q) begin
        dn_q   <= (state_q == ST_K0) ? (p00_q[W-1] ? W'(-p00_q) : W'(p00_q))
                                     : (p10_q[W-1] ? W'(-p10_q) : W'(p10_q));
        dneg_q <= (state_q == ST_K0) ? p00_q[W-1] : p10_q[W-1];
        dr_q   <= '0;
        dq_q   <= '0;
      end else begin
        dr_q <= rge ? (rsh - {1'b0, s_q}) : rsh;
        dq_q <= qn;
        if (dcnt_q > CW'(FracBits)) dn_q <= {dn_q[W-2:0], 1'b0};
      end
    end
    if (dlast) begin
      if (state_q == ST_K0) k0_q <= dneg_q ? ((qn > cap) ? SMin : dat_t'(-qn[W-1:0]))
                                           : ((qn > (W+2)'(SMax)) ? SMax : dat_t'(qn[W-1:0]));
      else k1_q <= dneg_q ? ((qn > cap) ? SMin : dat_t'(-qn[W-1:0]))
                          : ((qn > (W+2)'(SMax)) ? SMax : dat_t'(qn[W-1:0]));
    end
  end

  assign out_valid_o         = out_valid_q;
  assign depth_estimate_o    = od_q[IoW-1:0];
  assign velocity_estimate_o = ov_q[IoW-1:0];

endmodule

// ===== rtl/kdv_checker.sv =====
`include "kalman_depth_velocity_estimator_core_defines.svh"
module kdv_checker
  import kdv_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic signed [IoW-1:0] depth_estimate_o
);
  `KDV_NEVER(a_no_ready_while_out, clk_i, rst_ni, out_valid_o && in_ready_o && $past(in_ready_o) && $past(in_valid_i), "accepted while result pending")
  `KDV_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready right after accept")
  `KDV_ASSERT(a_no_out_soon, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !($rose(out_valid_o)), "result too early")
  `KDV_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(depth_estimate_o)), "stalled result changed")
endmodule

bind kalman_depth_velocity_estimator_core kdv_checker u_kdv_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .depth_estimate_o(depth_estimate_o)
);

// ===== tb/tb_top.sv =====
module tb_top;
  import kdv_pkg::*;

  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam longint ONE_Q = 64'sd65536;
  localparam int WDOG_LIMIT = 20000;
  localparam int NPHASE = 8;
  localparam int ITEMS_PER_PHASE = 130;

  typedef struct {
    logic signed [IoW-1:0] depth;
    logic signed [IoW-1:0] vel;
  } estimate_t;

  typedef struct {
    logic signed [IoW-1:0] sample;
    bit                    typed;
    logic signed [IoW-1:0] depth;
    logic signed [IoW-1:0] vel;
  } directed_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  cfg_idx_e              cfg_idx_i = CFG_TIME_STEP;
  logic [CfgDataW-1:0]   cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic signed [IoW-1:0] measured_depth_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic signed [IoW-1:0] depth_estimate_o;
  logic signed [IoW-1:0] velocity_estimate_o;

  kalman_depth_velocity_estimator_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .measured_depth_i,
    .out_valid_o, .out_ready_i, .depth_estimate_o, .velocity_estimate_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // filter state and registers mirrored by the predictor
  longint f_depth, f_vel, f_pdd, f_pdv, f_pvd, f_pvv;
  longint unsigned r_dt, r_qd, r_qv, r_meas;

  estimate_t expected_q[$];
  int  error_count = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;

  function automatic longint clamp_q(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint apply_sign(longint unsigned m, bit neg);
    if (neg) return (m > longint'(SMAX) + 1) ? SMIN : -longint'(m);
    return (m > longint'(SMAX)) ? SMAX : longint'(m);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint unsigned p;
    p = mag(a) * mag(b);
    p = (p + 64'd32768) >> 16;
    return apply_sign(p, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_gain(longint p, longint s);
    longint unsigned q;
    q = (mag(p) << 16) / longint'(s);
    if (q > longint'(SMAX) + 1) q = longint'(SMAX) + 2;
    return apply_sign(q, p < 0);
  endfunction

  function automatic void filter_reset();
    f_depth = 0; f_vel = 0;
    f_pdd = ONE_Q; f_pdv = 0; f_pvd = 0; f_pvv = ONE_Q;
    r_dt = 64'(DtReset); r_qd = 64'(QdReset); r_qv = 64'(QvReset); r_meas = 64'(RReset);
  endfunction

  function automatic estimate_t filter_sample(logic signed [IoW-1:0] sample);
    longint z, dt, t, p00, p01, p10, p11, y, s, k0, k1, omk;
    estimate_t e;
    z = longint'(sample);
    dt = longint'(r_dt);
    f_depth = clamp_q(f_depth + fx_mul(dt, f_vel));
    t = clamp_q(f_pvd + f_pdv);
    p00 = clamp_q(f_pdd + fx_mul(dt, t));
    p00 = clamp_q(p00 + fx_mul(fx_mul(dt, dt), f_pvv));
    p00 = clamp_q(p00 + longint'(r_qd));
    p01 = clamp_q(f_pdv + fx_mul(dt, f_pvv));
    p10 = clamp_q(f_pvd + fx_mul(dt, f_pvv));
    p11 = clamp_q(f_pvv + longint'(r_qv));
    y = clamp_q(z - f_depth);
    s = clamp_q(p00 + longint'(r_meas));
    if (s > 0) begin
      k0 = fx_gain(p00, s);
      k1 = fx_gain(p10, s);
    end else begin
      k0 = 0;
      k1 = 0;
    end
    f_depth = clamp_q(f_depth + fx_mul(k0, y));
    f_vel = clamp_q(f_vel + fx_mul(k1, y));
    omk = clamp_q(ONE_Q - k0);
    f_pdd = fx_mul(omk, p00);
    f_pdv = fx_mul(omk, p01);
    f_pvd = clamp_q(p10 - fx_mul(k1, p00));
    f_pvv = clamp_q(p11 - fx_mul(k1, p01));
    e.depth = f_depth[IoW-1:0];
    e.vel = f_vel[IoW-1:0];
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [IoW-1:0] got, logic [IoW-1:0] want);
    error_count++;
    $display("tb_top: %s mismatch got %h want %h", what, got, want);
  endtask

  task automatic write_reg(cfg_idx_e idx, longint unsigned value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[CfgDataW-1:0];
    @(posedge clk_i);
    case (idx)
      CFG_TIME_STEP: r_dt = value & 64'h1ffff;
      CFG_DEPTH_Q:   r_qd = value & 64'h1fffff;
      CFG_VEL_Q:     r_qv = value & 64'h1fffff;
      CFG_MEAS_R:    r_meas = value & 64'h1fffff;
      default: ;
    endcase
  endtask

  task automatic configure(longint unsigned dt, longint unsigned qd,
                           longint unsigned qv, longint unsigned rm);
    write_reg(CFG_TIME_STEP, dt);
    write_reg(CFG_DEPTH_Q, qd);
    write_reg(CFG_VEL_Q, qv);
    write_reg(CFG_MEAS_R, rm);
    cfg_we_i <= 1'b0;
  endtask

  // one transaction; the caller lowers valid before any gap
  task automatic send_sample(logic signed [IoW-1:0] sample, bit typed, estimate_t want);
    estimate_t e;
    in_valid_i <= 1'b1;
    measured_depth_i <= sample;
    do @(posedge clk_i); while (!in_ready_o);
    e = filter_sample(sample);
    expected_q.insert(expected_q.size(), typed ? want : e);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [IoW-1:0] pick_sample();
    int sel;
    longint v;
    sel = $urandom_range(99);
    if (sel < 60) begin
      v = f_depth + $signed($urandom_range(0, 2 * 655360)) - 655360;
      return IoW'(clamp_q(v));
    end
    if (sel < 85) return $urandom;
    case ($urandom_range(3))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      default: return $signed($urandom_range(0, 7)) - 4;
    endcase
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 9);
  end

  always @(posedge clk_i) begin
    estimate_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        error_count++;
        $display("tb_top: unexpected result transaction");
      end else begin
        want = expected_q.pop_front();
        if (depth_estimate_o !== want.depth)
          report_mismatch("depth_estimate", depth_estimate_o, want.depth);
        if (velocity_estimate_o !== want.vel)
          report_mismatch("velocity_estimate", velocity_estimate_o, want.vel);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  directed_row_t directed[] = '{
    '{32'sd0, 1'b1, 32'sd0, 32'sd0},
    '{32'sh7fffffff, 1'b0, '0, '0},
    '{32'sh80000000, 1'b0, '0, '0},
    '{32'sd1, 1'b0, '0, '0},
    '{-32'sd1, 1'b0, '0, '0},
    '{32'sd65536, 1'b0, '0, '0},
    '{-32'sd65536, 1'b0, '0, '0},
    '{32'sh55555555, 1'b0, '0, '0},
    '{32'shaaaaaaaa, 1'b0, '0, '0},
    '{32'sd655360, 1'b0, '0, '0},
    '{32'sd655360, 1'b0, '0, '0},
    '{32'sh7fffffff, 1'b0, '0, '0}
  };

  longint unsigned phase_cfg[NPHASE][4] = '{
    '{1311, 1311, 3277, 16384},
    '{0, 0, 0, 0},
    '{1, 0, 0, 1},
    '{65536, 1048576, 1048576, 1048576},
    '{131071, 2097151, 2097151, 2097151},
    '{0, 0, 0, 1},
    '{3277, 655, 1311, 8192},
    '{65536, 0, 65536, 0}
  };

  initial begin
    estimate_t none;
    none.depth = '0;
    none.vel = '0;
    filter_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      send_sample(directed[i].sample, directed[i].typed,
                  '{directed[i].depth, directed[i].vel});
    end
    drain();
    for (int ph = 0; ph < NPHASE; ph++) begin
      if (ph == 6)
        configure($urandom_range(1, 65536), $urandom_range(0, 1048576),
                  $urandom_range(0, 1048576), $urandom_range(1, 1048576));
      else
        configure(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2], phase_cfg[ph][3]);
      calm = (ph == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        maybe_gap();
        send_sample(pick_sample(), 1'b0, none);
      end
      drain();
    end
    calm = 1'b0;
    repeat (150) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/kdv_pkg.sv
rtl/kalman_depth_velocity_estimator_core.sv
rtl/kdv_checker.sv
tb/tb_top.sv
